FILE: sv/e2c_pkg.sv
// ----------------------------------------------------------------------------
// e2c_pkg
// Shared constants, tables and types for the seconds-to-calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package e2c_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned UNIT_W     = 16;
  localparam int unsigned CFG_ADDR_W = 3;

  localparam logic [DATA_W-1:0] RESET_EPOCH = 32'd946681200;

  // register index, taken from the word address bits of paddr
  localparam logic REG_EPOCH_OFFSET = 1'b0;

  localparam logic [11:0] BASE_YEAR     = 12'd2000;
  localparam logic [UNIT_W-1:0] DAYS_PER_YEAR = 16'd365;
  localparam logic [UNIT_W-1:0] DAYS_PER_QUAD = 16'd1461;

  // reciprocals for division by multiply and shift:
  // /60 takes the product down by 37, /24 by 36, /7 by 34
  localparam logic [DATA_W-1:0] RECIP_DIV60 = 32'h8888_8889;
  localparam logic [DATA_W-1:0] RECIP_DIV24 = 32'hAAAA_AAAB;
  localparam logic [DATA_W-1:0] RECIP_DIV7  = 32'h9249_2493;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  day_of_week;
  } e2c_result_t;

  // days in month, month numbered 1..12, february as a common year
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    begin
      unique case (mon)
        4'd2:                       len = 5'd28;
        4'd4, 4'd6, 4'd9, 4'd11:    len = 5'd30;
        default:                    len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // month term of the weekday sum
  function automatic logic [2:0] month_key(input logic [3:0] mon);
    logic [2:0] key;
    begin
      unique case (mon)
        4'd1:    key = 3'd0;
        4'd2:    key = 3'd3;
        4'd3:    key = 3'd2;
        4'd4:    key = 3'd5;
        4'd5:    key = 3'd0;
        4'd6:    key = 3'd3;
        4'd7:    key = 3'd5;
        4'd8:    key = 3'd1;
        4'd9:    key = 3'd4;
        4'd10:   key = 3'd6;
        4'd11:   key = 3'd2;
        4'd12:   key = 3'd4;
        default: key = 3'd0;
      endcase
      return key;
    end
  endfunction

endpackage

`default_nettype wire

FILE: sv/e2c_csub.sv
// ----------------------------------------------------------------------------
// e2c_csub
// Compare-and-subtract unit shared by the year and month steps of the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_csub
  import e2c_pkg::*;
(
  input  wire logic [UNIT_W-1:0] op_a,
  input  wire logic [UNIT_W-1:0] op_b,
  output logic      [UNIT_W-1:0] diff,
  output logic                   ge
);

  logic [UNIT_W:0] full;

  assign full = {1'b0, op_a} - {1'b0, op_b};
  assign diff = full[UNIT_W-1:0];
  assign ge   = ~full[UNIT_W];

endmodule

`default_nettype wire

FILE: sv/e2c_cfg.sv
// ----------------------------------------------------------------------------
// e2c_cfg
// APB register holding the epoch offset.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_cfg
  import e2c_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready,
  output logic      [DATA_W-1:0]     epoch_offset
);

  logic [DATA_W-1:0] epoch_offset_r;
  logic              sel_epoch;

  assign pready    = 1'b1;
  assign sel_epoch = (paddr[CFG_ADDR_W-1:2] == REG_EPOCH_OFFSET);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_offset_r <= RESET_EPOCH;
    end else if (psel && penable && pwrite && pready && sel_epoch) begin
      epoch_offset_r <= pwdata;
    end
  end

  assign prdata       = sel_epoch ? epoch_offset_r : '0;
  assign epoch_offset = epoch_offset_r;

endmodule

`default_nettype wire

FILE: sv/e2c_seq.sv
// ----------------------------------------------------------------------------
// e2c_seq
// Sequencer: reciprocal divisions on one shared multiplier, then year and
// month peeling on one compare-subtract unit, then the weekday.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_seq
  import e2c_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DATA_W-1:0] elapsed,
  output logic                   busy,
  output logic                   res_valid,
  output e2c_result_t            res
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEC_MUL, S_SEC_FIX, S_MIN_MUL, S_MIN_FIX, S_HR_MUL, S_HR_FIX,
    S_YEAR4, S_YEAR1, S_MONTH, S_WSUM, S_WD_MUL, S_WD_FIX
  } state_t;

  state_t            state_r;
  logic [DATA_W-1:0] num_r;
  logic [DATA_W-1:0] quot_r;
  logic [UNIT_W-1:0] days_r;
  logic [7:0]        yrs_r;
  logic [3:0]        mon_r;
  logic [5:0]        sec_r;
  logic [5:0]        min_r;
  logic [4:0]        hr_r;
  logic [2:0]        dow_r;
  logic              valid_r;

  logic [UNIT_W-1:0] op_a;
  logic [UNIT_W-1:0] op_b;
  logic [UNIT_W-1:0] diff;
  logic              ge;

  logic [DATA_W-1:0]   recip;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0]   quot;
  logic [5:0]          rem60;
  logic [4:0]          rem24;
  logic [2:0]          rem7;
  logic                leap;
  logic [4:0]          mlen;
  logic [11:0]         year_w;
  logic [11:0]         wy;
  logic [4:0]          c100;
  logic [2:0]          c400;
  logic [12:0]         wsum;

  e2c_csub u_csub (
    .op_a (op_a),
    .op_b (op_b),
    .diff (diff),
    .ge   (ge)
  );

  // shared 32 x 32 multiplier, quotient taken from the top of the product
  assign prod = {{DATA_W{1'b0}}, num_r} * {{DATA_W{1'b0}}, recip};

  always_comb begin
    recip = RECIP_DIV60;
    quot  = {5'd0, prod[63:37]};
    unique case (state_r)
      S_HR_MUL: begin
        recip = RECIP_DIV24;
        quot  = {4'd0, prod[63:36]};
      end
      S_WD_MUL: begin
        recip = RECIP_DIV7;
        quot  = {2'd0, prod[63:34]};
      end
      default: begin
        recip = RECIP_DIV60;
        quot  = {5'd0, prod[63:37]};
      end
    endcase
  end

  // remainder from the low bits only: 60, 24 and 7 are -4, -8 and -1
  // modulo 64, 32 and 8
  assign rem60 = num_r[5:0] + {quot_r[3:0], 2'b00};
  assign rem24 = num_r[4:0] + {quot_r[1:0], 3'b000};
  assign rem7  = num_r[2:0] + quot_r[2:0];

  assign leap = (yrs_r[1:0] == 2'd0);
  assign mlen = month_len(mon_r) + {4'd0, (leap && (mon_r == 4'd2))};

  assign op_a = days_r;
  always_comb begin
    op_b = DAYS_PER_QUAD;
    unique case (state_r)
      S_YEAR1: op_b = DAYS_PER_YEAR + {{(UNIT_W-1){1'b0}}, leap};
      S_MONTH: op_b = {{(UNIT_W-5){1'b0}}, mlen};
      default: op_b = DAYS_PER_QUAD;
    endcase
  end

  // weekday sum; the year reaching here lies in 1999..2136, so the century
  // terms reduce to compares
  assign year_w = BASE_YEAR + {4'd0, yrs_r};
  assign wy     = year_w - {11'd0, (mon_r < 4'd3)};
  always_comb begin
    priority if (wy >= 12'd2100) c100 = 5'd21;
    else if (wy >= 12'd2000)     c100 = 5'd20;
    else                         c100 = 5'd19;
    c400 = (wy >= 12'd2000) ? 3'd5 : 3'd4;
  end
  assign wsum = {1'b0, wy} + {3'd0, wy[11:2]} + {10'd0, c400}
              + {10'd0, month_key(mon_r)} + {8'd0, days_r[4:0]} + 13'd1
              - {8'd0, c100};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            num_r   <= elapsed;
            state_r <= S_SEC_MUL;
          end
        end
        S_SEC_MUL: begin
          quot_r  <= quot;
          state_r <= S_SEC_FIX;
        end
        S_SEC_FIX: begin
          sec_r   <= rem60;
          num_r   <= quot_r;
          state_r <= S_MIN_MUL;
        end
        S_MIN_MUL: begin
          quot_r  <= quot;
          state_r <= S_MIN_FIX;
        end
        S_MIN_FIX: begin
          min_r   <= rem60;
          num_r   <= quot_r;
          state_r <= S_HR_MUL;
        end
        S_HR_MUL: begin
          quot_r  <= quot;
          state_r <= S_HR_FIX;
        end
        S_HR_FIX: begin
          hr_r    <= rem24;
          days_r  <= quot_r[UNIT_W-1:0];
          yrs_r   <= '0;
          state_r <= S_YEAR4;
        end
        // whole four-year blocks first, same leap pattern as single years
        S_YEAR4: begin
          if (ge) begin
            days_r <= diff;
            yrs_r  <= yrs_r + 8'd4;
          end else begin
            state_r <= S_YEAR1;
          end
        end
        S_YEAR1: begin
          if (ge) begin
            days_r <= diff;
            yrs_r  <= yrs_r + 8'd1;
          end else begin
            mon_r   <= 4'd1;
            state_r <= S_MONTH;
          end
        end
        S_MONTH: begin
          if (ge && (mon_r < 4'd12)) begin
            days_r <= diff;
            mon_r  <= mon_r + 4'd1;
          end else begin
            state_r <= S_WSUM;
          end
        end
        S_WSUM: begin
          num_r   <= {19'd0, wsum};
          state_r <= S_WD_MUL;
        end
        S_WD_MUL: begin
          quot_r  <= quot;
          state_r <= S_WD_FIX;
        end
        S_WD_FIX: begin
          // remainder zero means sunday
          dow_r   <= (rem7 == 3'd0) ? 3'd7 : rem7;
          valid_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = valid_r;

  always_comb begin
    res.year        = year_w;
    res.month       = mon_r;
    res.day         = days_r[4:0] + 5'd1;
    res.hour        = hr_r;
    res.minute      = min_r;
    res.second      = sec_r;
    res.day_of_week = dow_r;
  end

endmodule

`default_nettype wire

FILE: sv/epoch_seconds_to_calendar_top.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Seconds count to calendar date, time of day and weekday.
//
//   channel   handshake                  payload
//   input     start / busy               in_seconds_count
//   result    out_valid (one-cycle)      out_year .. out_day_of_week
//   config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// busy stays high while a request is worked: the seconds, minutes and hours
// splits, each a multiply and a fix state on the shared reciprocal multiplier,
// then four-year, single-year and month steps on the compare-subtract unit, a
// sum state and the weekday multiply and fix states. The result strobe comes
// in the cycle busy falls. Reset is synchronous and loads the default epoch
// offset. The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_top
  import e2c_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [31:0]           in_seconds_count,
  output logic                       out_valid,
  output logic      [11:0]           out_year,
  output logic      [3:0]            out_month,
  output logic      [4:0]            out_day,
  output logic      [4:0]            out_hour,
  output logic      [5:0]            out_minute,
  output logic      [5:0]            out_second,
  output logic      [2:0]            out_day_of_week,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0]     pwdata,
  output logic      [DATA_W-1:0]     prdata,
  output logic                       pready
);

  logic [DATA_W-1:0] epoch_offset;
  logic [DATA_W-1:0] elapsed;
  e2c_result_t       res;

  e2c_cfg u_cfg (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .epoch_offset (epoch_offset)
  );

  // wraps modulo 2^32 below the offset
  assign elapsed = in_seconds_count - epoch_offset;

  e2c_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .elapsed   (elapsed),
    .busy      (busy),
    .res_valid (out_valid),
    .res       (res)
  );

  assign out_year        = res.year;
  assign out_month       = res.month;
  assign out_day         = res.day;
  assign out_hour        = res.hour;
  assign out_minute      = res.minute;
  assign out_second      = res.second;
  assign out_day_of_week = res.day_of_week;

endmodule

`default_nettype wire

FILE: sv/e2c_checker.sv
// ----------------------------------------------------------------------------
// e2c_checker
// Port-level checks on the converter's request and result behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

module e2c_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic [3:0]  out_month,
  input wire logic [4:0]  out_day,
  input wire logic [4:0]  out_hour,
  input wire logic [5:0]  out_minute,
  input wire logic [5:0]  out_second,
  input wire logic [2:0]  out_day_of_week
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted request");

  a_result_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result strobe outside end of a request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day >= 5'd1
                   && out_day_of_week >= 3'd1 && out_day_of_week <= 3'd7))
    else $error("date field out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59 && out_second <= 6'd59))
    else $error("time field out of range");

endmodule

bind epoch_seconds_to_calendar_top e2c_checker u_e2c_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .out_valid       (out_valid),
  .out_month       (out_month),
  .out_day         (out_day),
  .out_hour        (out_hour),
  .out_minute      (out_minute),
  .out_second      (out_second),
  .out_day_of_week (out_day_of_week)
);

`default_nettype wire
